@@ hw/rtl/hhd_pkg.sv @@
package hhd_pkg;

   localparam int COUNT_W        = 20;
   localparam int TOTAL_W        = 28;
   localparam int ROOT_W         = 36;
   localparam int DIST_W         = 17;
   localparam int PROD_W         = 2 * TOTAL_W;
   localparam int RAD_W          = 2 * ROOT_W;
   localparam int REM_W          = ROOT_W + 2;
   localparam int STEP_W         = 6;
   localparam int BIN_ROOT_STEPS = 28;
   localparam int TOT_ROOT_STEPS = 36;
   localparam int DIV_STEPS      = 17;

   localparam logic [DIST_W-1:0] ONE_Q16 = 17'h10000;

   typedef struct packed {
      logic [COUNT_W-1:0] count_one;
      logic [COUNT_W-1:0] count_two;
      logic               last_bin;
   } hhd_bin_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              sum_zero;
   } hhd_result_type;

   typedef struct packed {
      logic [REM_W-1:0] diff;
      logic             borrow;
   } hhd_csu_type;

endpackage

@@ hw/rtl/hhd_if.sv @@
interface hhd_req_if;
   logic                         valid;
   logic                         ready;
   logic [hhd_pkg::COUNT_W-1:0]  count_one;
   logic [hhd_pkg::COUNT_W-1:0]  count_two;
   logic                         last_bin;

   modport source (output valid, count_one, count_two, last_bin, input ready);
   modport sink   (input valid, count_one, count_two, last_bin, output ready);
endinterface

interface hhd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hhd_pkg::DIST_W-1:0]  distance;
   logic                        sum_zero;

   modport source (output valid, distance, sum_zero, input ready);
   modport sink   (input valid, distance, sum_zero, output ready);
endinterface

@@ hw/rtl/hhd_csu.sv @@
module hhd_csu (
   input  logic [hhd_pkg::REM_W-1:0] a,
   input  logic [hhd_pkg::REM_W-1:0] b,
   output hhd_pkg::hhd_csu_type      res
);

   logic [hhd_pkg::REM_W:0] sub;

   assign sub        = {1'b0, a} - {1'b0, b};
   assign res.diff   = sub[hhd_pkg::REM_W-1:0];
   assign res.borrow = sub[hhd_pkg::REM_W];

endmodule

@@ hw/rtl/hhd_core.sv @@
module hhd_core #(
   parameter int MAX_BINS   = 256,
   parameter int COUNT_BITS = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  hhd_pkg::hhd_bin_type     in_bin,
   input  logic                     res_ready,
   output logic                     res_valid,
   output hhd_pkg::hhd_result_type  res
);

   localparam int EFF_BITS = (COUNT_BITS < hhd_pkg::COUNT_W) ? COUNT_BITS : hhd_pkg::COUNT_W;
   localparam logic [hhd_pkg::COUNT_W-1:0] CNT_MASK =
      hhd_pkg::COUNT_W'((64'd1 << EFF_BITS) - 64'd1);
   localparam int BIN_W = $clog2(MAX_BINS + 1);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_MUL    = 8'b0000_0010,
      S_ROOT   = 8'b0000_0100,
      S_ACC    = 8'b0000_1000,
      S_TMUL   = 8'b0001_0000,
      S_DIVCHK = 8'b0010_0000,
      S_DIV    = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   state_type                       state_ff, state_in;
   logic [hhd_pkg::TOTAL_W-1:0]     total_one_ff, total_one_in;
   logic [hhd_pkg::TOTAL_W-1:0]     total_two_ff, total_two_in;
   logic [hhd_pkg::ROOT_W-1:0]      root_sum_ff, root_sum_in;
   logic [BIN_W-1:0]                bin_cnt_ff, bin_cnt_in;
   logic [hhd_pkg::COUNT_W-1:0]     c1_ff, c1_in;
   logic [hhd_pkg::COUNT_W-1:0]     c2_ff, c2_in;
   logic                            last_ff, last_in;
   logic                            final_ff, final_in;
   logic [hhd_pkg::RAD_W-1:0]       rad_ff, rad_in;
   logic [hhd_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic [hhd_pkg::ROOT_W-1:0]      root_ff, root_in;
   logic [hhd_pkg::ROOT_W-1:0]      den_ff, den_in;
   logic [hhd_pkg::STEP_W-1:0]      cnt_ff, cnt_in;
   hhd_pkg::hhd_result_type         res_ff, res_in;

   logic [hhd_pkg::TOTAL_W-1:0]     mul_a, mul_b;
   logic [hhd_pkg::PROD_W-1:0]      prod;
   logic [hhd_pkg::REM_W-1:0]       csu_a, csu_b;
   hhd_pkg::hhd_csu_type            csu;
   logic [hhd_pkg::TOTAL_W:0]       t1_sum, t2_sum;
   logic [hhd_pkg::ROOT_W:0]        rs_sum;
   logic [BIN_W-1:0]                bin_next;
   logic                            is_final;
   logic [hhd_pkg::DIST_W-1:0]      quot;

   // shared multiplier: per-bin count product, then the product of the totals
   assign mul_a = (state_ff == S_MUL) ? hhd_pkg::TOTAL_W'(c1_ff) : total_one_ff;
   assign mul_b = (state_ff == S_MUL) ? hhd_pkg::TOTAL_W'(c2_ff) : total_two_ff;
   assign prod  = {{hhd_pkg::TOTAL_W{1'b0}}, mul_a} * {{hhd_pkg::TOTAL_W{1'b0}}, mul_b};

   always_comb begin
      csu_a = {rem_ff[hhd_pkg::REM_W-3:0], rad_ff[hhd_pkg::RAD_W-1 -: 2]};
      csu_b = {root_ff, 2'b01};
      case (state_ff)
         S_DIVCHK: begin
            csu_a = {2'b00, root_sum_ff};
            csu_b = {1'b0, root_ff, 1'b0};
         end
         S_DIV: begin
            csu_a = {rem_ff[hhd_pkg::REM_W-2:0], rad_ff[hhd_pkg::RAD_W-1]};
            csu_b = {2'b00, den_ff};
         end
         default: begin
         end
      endcase
   end

   hhd_csu u_csu (
      .a   (csu_a),
      .b   (csu_b),
      .res (csu)
   );

   assign t1_sum   = {1'b0, total_one_ff} + (hhd_pkg::TOTAL_W+1)'(c1_ff);
   assign t2_sum   = {1'b0, total_two_ff} + (hhd_pkg::TOTAL_W+1)'(c2_ff);
   assign rs_sum   = {1'b0, root_sum_ff} + {1'b0, root_ff};
   assign bin_next = bin_cnt_ff + BIN_W'(1);
   assign is_final = last_ff || (bin_next >= BIN_W'(MAX_BINS));
   assign quot     = {root_ff[hhd_pkg::DIST_W-2:0], ~csu.borrow};

   assign in_ready  = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_OUT) && res_ready;
   assign res       = res_ff;

   always_comb begin
      state_in     = state_ff;
      total_one_in = total_one_ff;
      total_two_in = total_two_ff;
      root_sum_in  = root_sum_ff;
      bin_cnt_in   = bin_cnt_ff;
      c1_in        = c1_ff;
      c2_in        = c2_ff;
      last_in      = last_ff;
      final_in     = final_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      den_in       = den_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               c1_in    = in_bin.count_one & CNT_MASK;
               c2_in    = in_bin.count_two & CNT_MASK;
               last_in  = in_bin.last_bin;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            rad_in   = {prod[2*hhd_pkg::COUNT_W-1:0],
                        {(hhd_pkg::RAD_W-2*hhd_pkg::COUNT_W){1'b0}}};
            rem_in   = '0;
            root_in  = '0;
            final_in = 1'b0;
            cnt_in   = hhd_pkg::STEP_W'(hhd_pkg::BIN_ROOT_STEPS);
            state_in = S_ROOT;
         end
         S_ROOT: begin
            rem_in  = csu.borrow ? csu_a : csu.diff;
            root_in = {root_ff[hhd_pkg::ROOT_W-2:0], ~csu.borrow};
            rad_in  = {rad_ff[hhd_pkg::RAD_W-3:0], 2'b00};
            cnt_in  = cnt_ff - hhd_pkg::STEP_W'(1);
            if (cnt_ff == hhd_pkg::STEP_W'(1)) begin
               state_in = final_ff ? S_DIVCHK : S_ACC;
            end
         end
         S_ACC: begin
            total_one_in = t1_sum[hhd_pkg::TOTAL_W] ? '1 : t1_sum[hhd_pkg::TOTAL_W-1:0];
            total_two_in = t2_sum[hhd_pkg::TOTAL_W] ? '1 : t2_sum[hhd_pkg::TOTAL_W-1:0];
            root_sum_in  = rs_sum[hhd_pkg::ROOT_W] ? '1 : rs_sum[hhd_pkg::ROOT_W-1:0];
            bin_cnt_in   = bin_next;
            state_in     = is_final ? S_TMUL : S_IDLE;
         end
         S_TMUL: begin
            if ((total_one_ff == '0) || (total_two_ff == '0)) begin
               res_in.distance = hhd_pkg::ONE_Q16;
               res_in.sum_zero = 1'b1;
               state_in        = S_OUT;
            end else begin
               rad_in   = {prod, {(hhd_pkg::RAD_W-hhd_pkg::PROD_W){1'b0}}};
               rem_in   = '0;
               root_in  = '0;
               final_in = 1'b1;
               cnt_in   = hhd_pkg::STEP_W'(hhd_pkg::TOT_ROOT_STEPS);
               state_in = S_ROOT;
            end
         end
         S_DIVCHK: begin
            // root_sum >= 2*den means the coefficient is at least 2.0
            if (!csu.borrow) begin
               res_in.distance = '0;
               res_in.sum_zero = 1'b0;
               state_in        = S_OUT;
            end else begin
               den_in   = root_ff;
               rem_in   = {3'b000, root_sum_ff[hhd_pkg::ROOT_W-1:1]};
               rad_in   = {root_sum_ff[0], {(hhd_pkg::RAD_W-1){1'b0}}};
               root_in  = '0;
               cnt_in   = hhd_pkg::STEP_W'(hhd_pkg::DIV_STEPS);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = csu.borrow ? csu_a : csu.diff;
            root_in = {root_ff[hhd_pkg::ROOT_W-2:0], ~csu.borrow};
            rad_in  = {rad_ff[hhd_pkg::RAD_W-2:0], 1'b0};
            cnt_in  = cnt_ff - hhd_pkg::STEP_W'(1);
            if (cnt_ff == hhd_pkg::STEP_W'(1)) begin
               res_in.distance = quot[hhd_pkg::DIST_W-1] ? '0 : (hhd_pkg::ONE_Q16 - quot);
               res_in.sum_zero = 1'b0;
               state_in        = S_OUT;
            end
         end
         S_OUT: begin
            if (res_ready) begin
               total_one_in = '0;
               total_two_in = '0;
               root_sum_in  = '0;
               bin_cnt_in   = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_one_ff <= '0;
         total_two_ff <= '0;
         root_sum_ff  <= '0;
         bin_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         total_one_ff <= total_one_in;
         total_two_ff <= total_two_in;
         root_sum_ff  <= root_sum_in;
         bin_cnt_ff   <= bin_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      c1_ff    <= c1_in;
      c2_ff    <= c2_in;
      last_ff  <= last_in;
      final_ff <= final_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      den_ff   <= den_in;
      cnt_ff   <= cnt_in;
      res_ff   <= res_in;
   end

endmodule

@@ hw/rtl/hellinger_histogram_distance.sv @@
// Streaming Hellinger distance between two histograms, one bin pair per
// transfer on req_bus; the transfer flagged last_bin (or the MAX_BINS-th bin)
// produces one rsp_bus transfer with distance = 1 - BC in Q1.16 and sum_zero
// set when either total is zero. Square-root and divide steps share one
// 38-bit compare-subtract unit, one result bit per cycle. A bin passes accept,
// multiply, 28 square-root steps and accumulate; no new bin is taken meanwhile.
// The final bin adds multiply, 36 square-root steps, range check, 17 divide
// steps and result, skipping the divide when the check finds the coefficient
// at 2.0 or more, and the rest when a total is zero. The result is registered,
// so the next histogram can start while it waits.
module hellinger_histogram_distance #(
   parameter int MAX_BINS   = 256,
   parameter int COUNT_BITS = 20
) (
   input  logic       clock,
   input  logic       reset,
   hhd_req_if.sink    req_bus,
   hhd_rsp_if.source  rsp_bus
);

   hhd_pkg::hhd_bin_type     in_bin;
   hhd_pkg::hhd_result_type  core_res;
   logic                     core_res_valid;
   logic                     slot_free;
   logic                     rsp_valid_ff, rsp_valid_in;
   hhd_pkg::hhd_result_type  rsp_res_ff, rsp_res_in;

   assign in_bin.count_one = req_bus.count_one;
   assign in_bin.count_two = req_bus.count_two;
   assign in_bin.last_bin  = req_bus.last_bin;

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   hhd_core #(
      .MAX_BINS   (MAX_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_bin    (in_bin),
      .res_ready (slot_free),
      .res_valid (core_res_valid),
      .res       (core_res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (core_res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = core_res;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.distance = rsp_res_ff.distance;
   assign rsp_bus.sum_zero = rsp_res_ff.sum_zero;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      core_res_valid |-> slot_free)
      else $error("result written over a pending transfer");

   a_zero_sum_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.sum_zero) |-> (rsp_bus.distance == hhd_pkg::ONE_Q16))
      else $error("zero-sum result without full distance");

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.distance <= hhd_pkg::ONE_Q16))
      else $error("distance above 1.0");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("bin taken while previous bin in progress");

endmodule
